### rtl/core/uv_sphere_triangle_index_generator_top_assert.svh
// Assertion macros shared by the UV-sphere triangle index generator RTL.
`ifndef UV_SPHERE_TRIANGLE_INDEX_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_TRIANGLE_INDEX_GENERATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define UVS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define UVS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UVS_ASSERT(label, clk, rst_n, prop, msg)
`define UVS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/core/uvs_pkg.sv
// Package with widths, reset values, register codes and types of the generator.
package uvs_pkg;

  localparam int IDX_W = 28;

  localparam int LON_BITS_DEF   = 10;
  localparam int LAT_BITS_DEF   = 10;
  localparam int LAYER_BITS_DEF = 8;

  localparam int LON_RESET   = 8;
  localparam int LAT_RESET   = 8;
  localparam int LAYER_RESET = 1;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LON    = 2'd0,
    CFG_LAT    = 2'd1,
    CFG_LAYERS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic             layer_end;
    logic             mesh_end;
  } tri_t;

endpackage

### rtl/core/uvs_walker.sv
// Mesh walker: sequence counters, row vertex tracking and triangle assembly.
`include "uv_sphere_triangle_index_generator_top_assert.svh"

module uvs_walker
  import uvs_pkg::*;
#(
  parameter int LON_BITS   = LON_BITS_DEF,
  parameter int LAT_BITS   = LAT_BITS_DEF,
  parameter int LAYER_BITS = LAYER_BITS_DEF,
  localparam int VERT_W    = LON_BITS + LAT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  restart_i,
  input  logic [LON_BITS-1:0]   lon_last_i,
  input  logic [LAT_BITS-1:0]   lat_last_i,
  input  logic [LAYER_BITS-1:0] layer_last_i,
  input  logic [VERT_W-1:0]     layer_step_i,
  output tri_t                  tri_o
);

  localparam int SUM_W = (IDX_W > VERT_W + 1) ? IDX_W : VERT_W + 1;

  logic [LAYER_BITS-1:0] layer_q, layer_d, cur_layer;
  logic [LAT_BITS-1:0]   band_q, band_d, cur_band;
  logic [LON_BITS-1:0]   col_q, col_d, cur_col;
  logic                  half_q, half_d, cur_half;
  logic [IDX_W-1:0]      base_q, base_d, cur_base;
  logic [VERT_W-1:0]     top_q, top_d, cur_top;
  logic [VERT_W-1:0]     bot_q, bot_d, cur_bot;
  logic [VERT_W-1:0]     tstart_q, tstart_d, cur_tstart;
  logic [VERT_W-1:0]     bstart_q, bstart_d, cur_bstart;

  logic [VERT_W:0] top_inc, bot_inc, va, vb, vc, tr, br;
  logic            last_col, band_done, layer_done, mesh_done;
  logic [SUM_W-1:0] sum_a, sum_b, sum_c, sum_base;

  // Restart replaces the stored position with the start of the mesh.
  assign cur_layer  = restart_i ? '0 : layer_q;
  assign cur_band   = restart_i ? '0 : band_q;
  assign cur_col    = restart_i ? '0 : col_q;
  assign cur_half   = restart_i ? 1'b0 : half_q;
  assign cur_base   = restart_i ? '0 : base_q;
  assign cur_top    = restart_i ? '0 : top_q;
  assign cur_bot    = restart_i ? VERT_W'(1) : bot_q;
  assign cur_tstart = restart_i ? '0 : tstart_q;
  assign cur_bstart = restart_i ? VERT_W'(1) : bstart_q;

  assign top_inc  = {1'b0, cur_top} + (VERT_W + 1)'(1);
  assign bot_inc  = {1'b0, cur_bot} + (VERT_W + 1)'(1);
  assign last_col = cur_col >= lon_last_i;
  assign tr       = last_col ? {1'b0, cur_tstart} : top_inc;
  assign br       = last_col ? {1'b0, cur_bstart} : bot_inc;

  always_comb begin
    va         = '0;
    vb         = '0;
    vc         = '0;
    band_done  = 1'b0;
    layer_done = 1'b0;
    mesh_done  = 1'b0;
    layer_d    = cur_layer;
    band_d     = cur_band;
    col_d      = cur_col;
    half_d     = cur_half;
    base_d     = cur_base;
    top_d      = cur_top;
    bot_d      = cur_bot;
    tstart_d   = cur_tstart;
    bstart_d   = cur_bstart;

    if (cur_band == '0) begin
      // North fan: pole, next bottom, bottom.
      va    = {1'b0, cur_top};
      vb    = br;
      vc    = {1'b0, cur_bot};
      bot_d = bot_inc[VERT_W-1:0];
      if (last_col) begin
        top_d     = top_inc[VERT_W-1:0];
        band_done = 1'b1;
      end
    end else if (cur_band < lat_last_i) begin
      // Middle band: two triangles per quad.
      if (!cur_half) begin
        va     = {1'b0, cur_bot};
        vb     = {1'b0, cur_top};
        vc     = br;
        half_d = 1'b1;
      end else begin
        va        = br;
        vb        = {1'b0, cur_top};
        vc        = tr;
        half_d    = 1'b0;
        top_d     = top_inc[VERT_W-1:0];
        bot_d     = bot_inc[VERT_W-1:0];
        band_done = last_col;
      end
    end else begin
      // South fan: pole, top, next top.
      va    = {1'b0, cur_bot};
      vb    = {1'b0, cur_top};
      vc    = tr;
      top_d = top_inc[VERT_W-1:0];
      if (last_col) begin
        band_done  = 1'b1;
        layer_done = 1'b1;
        mesh_done  = cur_layer >= layer_last_i;
      end
    end

    sum_base = SUM_W'(cur_base) + SUM_W'(layer_step_i);

    if (mesh_done) begin
      layer_d  = '0;
      band_d   = '0;
      col_d    = '0;
      half_d   = 1'b0;
      base_d   = '0;
      top_d    = '0;
      bot_d    = VERT_W'(1);
      tstart_d = '0;
      bstart_d = VERT_W'(1);
    end else if (layer_done) begin
      layer_d  = cur_layer + LAYER_BITS'(1);
      base_d   = sum_base[IDX_W-1:0];
      band_d   = '0;
      col_d    = '0;
      half_d   = 1'b0;
      top_d    = '0;
      bot_d    = VERT_W'(1);
      tstart_d = '0;
      bstart_d = VERT_W'(1);
    end else if (band_done) begin
      band_d   = cur_band + LAT_BITS'(1);
      col_d    = '0;
      half_d   = 1'b0;
      tstart_d = top_d;
      bstart_d = bot_d;
    end else if (!half_d) begin
      col_d = cur_col + LON_BITS'(1);
    end
  end

  assign sum_a = SUM_W'(cur_base) + SUM_W'(va);
  assign sum_b = SUM_W'(cur_base) + SUM_W'(vb);
  assign sum_c = SUM_W'(cur_base) + SUM_W'(vc);

  assign tri_o.corner_a  = sum_a[IDX_W-1:0];
  assign tri_o.corner_b  = sum_b[IDX_W-1:0];
  assign tri_o.corner_c  = sum_c[IDX_W-1:0];
  assign tri_o.layer_end = layer_done;
  assign tri_o.mesh_end  = mesh_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q  <= '0;
      band_q   <= '0;
      col_q    <= '0;
      half_q   <= 1'b0;
      base_q   <= '0;
      top_q    <= '0;
      bot_q    <= VERT_W'(1);
      tstart_q <= '0;
      bstart_q <= VERT_W'(1);
    end else if (fire_i) begin
      layer_q  <= layer_d;
      band_q   <= band_d;
      col_q    <= col_d;
      half_q   <= half_d;
      base_q   <= base_d;
      top_q    <= top_d;
      bot_q    <= bot_d;
      tstart_q <= tstart_d;
      bstart_q <= bstart_d;
    end
  end

  `UVS_ASSERT(a_half_in_middle, clk_i, rst_ni, half_q |-> (band_q != '0),
              "second half flag set outside a middle band")
  `UVS_ASSERT(a_mesh_restart, clk_i, rst_ni,
              (fire_i && tri_o.mesh_end) |=> (layer_q == '0 && base_q == '0 && band_q == '0),
              "mesh end did not restart the sequence")
  `UVS_ASSERT(a_layer_rewind, clk_i, rst_ni,
              (fire_i && tri_o.layer_end) |=> (band_q == '0 && col_q == '0 && top_q == '0),
              "layer end did not rewind band and column")

endmodule

### rtl/core/uv_sphere_triangle_index_generator_top.sv
// Top level of the UV-sphere triangle index generator.
//
// Usage:
//   Each request on the input channel (in_valid_i / in_stall_o) carries one
//   restart bit and produces exactly one triangle on the output channel
//   (out_valid_o / out_stall_i): three 28-bit vertex indices plus the
//   layer_end and mesh_end marks. restart_i = 1 emits the first triangle of
//   the mesh; 0 emits the next one. After the last triangle of the mesh the
//   sequence wraps to the first on its own.
//   A request taken at one edge shows its triangle on the outputs right
//   after that edge. One request per cycle is sustained while the receiver
//   does not stall; the walker's counters and one adder per corner sit
//   between the state registers and the output register.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes
//   lon_count, lat_count and layer_count; write only while no request is in
//   flight. The per-layer vertex count lon*(lat-1)+2 is multiplied out at
//   the write, so a request may follow in the very next cycle.
//   Reset loads lon 8, lat 8, layers 1, rewinds the sequence and empties
//   the output register. A stalled receiver holds the output register; a
//   new request is taken while it is full only if it is drained that cycle.
`include "uv_sphere_triangle_index_generator_top_assert.svh"

module uv_sphere_triangle_index_generator_top
  import uvs_pkg::*;
#(
  parameter int LON_BITS   = LON_BITS_DEF,
  parameter int LAT_BITS   = LAT_BITS_DEF,
  parameter int LAYER_BITS = LAYER_BITS_DEF,
  localparam int MAX_LL    = (LON_BITS > LAT_BITS) ? LON_BITS : LAT_BITS,
  localparam int CFG_W     = (MAX_LL > LAYER_BITS) ? MAX_LL : LAYER_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 restart_i,
  // triangle channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     corner_a_o,
  output logic [IDX_W-1:0]     corner_b_o,
  output logic [IDX_W-1:0]     corner_c_o,
  output logic                 layer_end_o,
  output logic                 mesh_end_o
);

  localparam int VERT_W = LON_BITS + LAT_BITS;

  // Configuration registers and the per-layer vertex count.
  logic [LON_BITS-1:0]   lon_q, lon_d;
  logic [LAT_BITS-1:0]   lat_q, lat_d;
  logic [LAYER_BITS-1:0] layers_q, layers_d;
  logic [VERT_W-1:0]     step_q, step_d;
  logic [LON_BITS-1:0]   lon_eff_d;
  logic [LAT_BITS-1:0]   lat_m1_d;
  logic [VERT_W-1:0]     step_prod;

  // Clamped last values fed to the walker.
  logic [LON_BITS-1:0]   lon_last;
  logic [LAT_BITS-1:0]   lat_last;
  logic [LAYER_BITS-1:0] layer_last;

  logic in_fire;
  tri_t tri_next;
  tri_t out_tri_q;
  logic out_valid_q, out_valid_d;

  // Decode a write; an index past the last register is dropped.
  always_comb begin
    lon_d    = lon_q;
    lat_d    = lat_q;
    layers_d = layers_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LON:    lon_d    = cfg_data_i[LON_BITS-1:0];
        CFG_LAT:    lat_d    = cfg_data_i[LAT_BITS-1:0];
        CFG_LAYERS: layers_d = cfg_data_i[LAYER_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // Multiply out the layer vertex count from the values being written.
  assign lon_eff_d = (lon_d == '0) ? LON_BITS'(1) : lon_d;
  assign lat_m1_d  = (lat_d < LAT_BITS'(2)) ? LAT_BITS'(1) : lat_d - LAT_BITS'(1);
  assign step_prod = VERT_W'(lon_eff_d) * VERT_W'(lat_m1_d);
  assign step_d    = step_prod + VERT_W'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_q    <= LON_BITS'(LON_RESET);
      lat_q    <= LAT_BITS'(LAT_RESET);
      layers_q <= LAYER_BITS'(LAYER_RESET);
      step_q   <= VERT_W'(LON_RESET * (LAT_RESET - 1) + 2);
    end else begin
      lon_q    <= lon_d;
      lat_q    <= lat_d;
      layers_q <= layers_d;
      step_q   <= step_d;
    end
  end

  // Zero or too small counts act as their minimum.
  assign lon_last   = (lon_q == '0) ? '0 : lon_q - LON_BITS'(1);
  assign lat_last   = (lat_q < LAT_BITS'(2)) ? LAT_BITS'(1) : lat_q - LAT_BITS'(1);
  assign layer_last = (layers_q == '0) ? '0 : layers_q - LAYER_BITS'(1);

  // Take a request whenever the output register is empty or drains now.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  uvs_walker #(
    .LON_BITS   (LON_BITS),
    .LAT_BITS   (LAT_BITS),
    .LAYER_BITS (LAYER_BITS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .restart_i    (restart_i),
    .lon_last_i   (lon_last),
    .lat_last_i   (lat_last),
    .layer_last_i (layer_last),
    .layer_step_i (step_q),
    .tri_o        (tri_next)
  );

  // Output register: load on a taken request, drop when drained, else hold.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_tri_q <= tri_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corner_a_o  = out_tri_q.corner_a;
  assign corner_b_o  = out_tri_q.corner_b;
  assign corner_c_o  = out_tri_q.corner_c;
  assign layer_end_o = out_tri_q.layer_end;
  assign mesh_end_o  = out_tri_q.mesh_end;

  `UVS_ASSERT(a_fire_shows, clk_i, rst_ni, in_fire |=> out_valid_o,
              "taken request did not reach the output register")
  `UVS_ASSERT(a_drain_empties, clk_i, rst_ni,
              (out_valid_o && !out_stall_i && !in_fire) |=> !out_valid_o,
              "drained output register stayed full")
  `UVS_ASSERT(a_mesh_implies_layer, clk_i, rst_ni,
              (out_valid_o && mesh_end_o) |-> layer_end_o,
              "mesh end without layer end")
  `UVS_ASSERT_ALWAYS(a_stall_needs_full, clk_i, in_stall_o |-> out_valid_q,
                     "request stalled while output register empty")

endmodule
